// ===== rtl/core/psc_pkg.sv =====
// ----------------------------------------------------------------------------
// Parabolic sine/cosine package
// Fixed-point constants, widths and the rounding helper shared by the core.
// ----------------------------------------------------------------------------
package psc_pkg;

  localparam int unsigned AngleW   = 16;
  localparam int unsigned TrigW    = 16;
  localparam int unsigned WrapW    = 15;

  localparam logic signed [16:0] AngPi     = 17'sd12868;
  localparam logic signed [16:0] AngTwoPi  = 17'sd25736;
  localparam logic signed [16:0] AngHalfPi = 17'sd6434;

  localparam logic signed [15:0] CoefB = 16'sd20861;
  localparam logic signed [15:0] CoefC = 16'sd6640;
  localparam logic signed [15:0] CoefP = 16'sd14746;

  localparam logic signed [16:0] OneQ14    = 17'sd16384;
  localparam logic signed [16:0] MinusOneQ14 = -17'sd16384;

  localparam int unsigned NumStages = 9;

  // Round a right shift to nearest, with ties away from zero.
  function automatic logic signed [47:0] round_shift(input logic signed [47:0] v,
                                                     input int unsigned sh);
    logic [47:0] mag;
    logic [47:0] half;
    logic [47:0] mag_r;
    mag   = v[47] ? 48'(-v) : 48'(v);
    half  = 48'd1 << (sh - 1);
    mag_r = (mag + half) >> sh;
    return v[47] ? -$signed(mag_r) : $signed(mag_r);
  endfunction

endpackage

// ===== rtl/core/parabolic_sine_cosine_core.sv =====
// ----------------------------------------------------------------------------
// Parabolic sine/cosine core
// Q3.12 angle in, Q1.14 sine and cosine out, by a refined parabola.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_ready_o    angle_i
// out       output     out_valid_o / out_ready_i  sine_o, cosine_o
//
// One transfer is accepted in every cycle in which the output is free.
// The angle wrap registers xs_q, then xs2_q and xc_q, feed the two product lanes.
// The pipeline stalls as a whole while a result waits; nothing is lost.
// Reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module parabolic_sine_cosine_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [psc_pkg::AngleW-1:0]    angle_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [psc_pkg::TrigW-1:0]     sine_o,
  output logic signed [psc_pkg::TrigW-1:0]     cosine_o
);
  import psc_pkg::*;

  logic                    advance;
  logic [NumStages-1:0]    valid_d, valid_q;
  logic signed [16:0]      ang_ext;
  logic signed [16:0]      xs_full;
  logic signed [WrapW-1:0] xs_d, xs_q, xs2_q;
  logic signed [16:0]      xc_full;
  logic signed [WrapW-1:0] xc_d, xc_q;

  assign advance    = !valid_q[NumStages-1] || out_ready_i;
  assign in_ready_o = advance;

  always_comb begin
    ang_ext = 17'(angle_i);
    if (ang_ext < -AngPi) begin
      xs_full = ang_ext + AngTwoPi;
    end else if (ang_ext > AngPi) begin
      xs_full = ang_ext - AngTwoPi;
    end else begin
      xs_full = ang_ext;
    end
    xs_d = WrapW'(xs_full);

    xc_full = 17'(xs_q) + AngHalfPi;
    if (xc_full > AngPi) begin
      xc_full = xc_full - AngTwoPi;
    end
    xc_d = WrapW'(xc_full);

    valid_d = {valid_q[NumStages-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      xs_q  <= xs_d;
      xs2_q <= xs_q;
      xc_q  <= xc_d;
    end
  end

  psc_sine_pipe u_sine (
    .clk_i (clk_i),
    .en_i  (advance),
    .x_i   (xs2_q),
    .y_o   (sine_o)
  );

  psc_sine_pipe u_cosine (
    .clk_i (clk_i),
    .en_i  (advance),
    .x_i   (xc_q),
    .y_o   (cosine_o)
  );

  assign out_valid_o = valid_q[NumStages-1];

  // Results never leave the saturation range.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(sine_o) <= 16'sd16384 && $signed(sine_o) >= -16'sd16384))
    else $error("sine out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(cosine_o) <= 16'sd16384 && $signed(cosine_o) >= -16'sd16384))
    else $error("cosine out of range");

  // A stall freezes every stage valid bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(valid_q))
    else $error("valid bits moved during a stall");

  // An accepted transfer occupies the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> valid_q[0])
    else $error("accepted transfer not captured");

endmodule

// ===== rtl/core/psc_sine_pipe.sv =====
// ----------------------------------------------------------------------------
// Parabolic sine lane
// Seven-stage pipeline from a wrapped Q12 angle to a saturated Q1.14 sine.
// ----------------------------------------------------------------------------
module psc_sine_pipe (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic signed [psc_pkg::WrapW-1:0]     x_i,
  output logic signed [psc_pkg::TrigW-1:0]     y_o
);
  import psc_pkg::*;

  logic signed [WrapW-1:0] x_abs;
  logic signed [29:0]      x_ext;
  logic signed [29:0]      lin_d, lin_q, lin2_q;
  logic signed [28:0]      sq_d, sq_q;
  logic signed [40:0]      prod_d, prod_q;
  logic signed [47:0]      quad;
  logic signed [30:0]      diff_d, diff_q;
  logic signed [15:0]      p_d, p_q, p2_q, p3_q;
  logic signed [15:0]      p_abs;
  logic signed [31:0]      t_full;
  logic signed [27:0]      t_d, t_q;
  logic signed [40:0]      pt_d, pt_q;
  logic signed [47:0]      r_wide;
  logic signed [16:0]      y_sum;
  logic signed [TrigW-1:0] y_d, y_q;

  always_comb begin
    x_abs  = x_i[WrapW-1] ? -x_i : x_i;
    x_ext  = 30'(x_i);
    lin_d  = x_ext * 30'(CoefB);
    sq_d   = 29'(x_i) * 29'(x_abs);
    prod_d = 41'(sq_q) * 41'(CoefC);
    quad   = round_shift(48'(prod_q), 12);
    diff_d = 31'(lin2_q) - 31'(quad);
    p_d    = 16'(round_shift(48'(diff_q), 12));
    p_abs  = p_q[15] ? -p_q : p_q;
    t_full = 32'(p_q) * 32'(p_abs) - (32'(p_q) <<< 14);
    t_d    = 28'(t_full);
    pt_d   = 41'(t_q) * 41'(CoefP);
    r_wide = round_shift(48'(pt_q), 30);
    y_sum  = 17'(p3_q) + 17'(r_wide);
    if (y_sum > OneQ14) begin
      y_d = TrigW'(OneQ14);
    end else if (y_sum < MinusOneQ14) begin
      y_d = TrigW'(MinusOneQ14);
    end else begin
      y_d = TrigW'(y_sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lin_q  <= lin_d;
      sq_q   <= sq_d;
      lin2_q <= lin_q;
      prod_q <= prod_d;
      diff_q <= diff_d;
      p_q    <= p_d;
      p2_q   <= p_q;
      t_q    <= t_d;
      p3_q   <= p2_q;
      pt_q   <= pt_d;
      y_q    <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ===== tb/tb_parabolic_sine_cosine_core.sv =====
// ----------------------------------------------------------------------------
// Parabolic sine/cosine core testbench
// Drives angles through the valid/ready input channel and checks every sine and
// cosine pair against a fixed-point predictor of the refined parabola or, for typed
// rows, a hand result. A short table of edge angles comes first, then random angles
// under three idling patterns. A long output stall fills the pipeline; input backs up.
// ----------------------------------------------------------------------------
module tb_parabolic_sine_cosine_core;

  import psc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandPerMode = 383;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned HoldAfter   = 900;
  localparam int unsigned DirRows     = 20;

  typedef struct packed {
    logic signed [TrigW-1:0] sine;
    logic signed [TrigW-1:0] cosine;
  } trig_t;

  typedef struct packed {
    logic signed [AngleW-1:0] angle;
    logic                     typed;
    logic signed [TrigW-1:0]  sine;
    logic signed [TrigW-1:0]  cosine;
  } angle_row_t;

  // Rows with typed set carry a result that can be worked out by hand.
  localparam angle_row_t DirTbl [DirRows] = '{
    '{16'sd0,      1'b1, 16'sd0,     16'sd16384},
    '{16'sd6434,   1'b1, 16'sd16384, 16'sd2},
    '{16'sd32767,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd32768, 1'b0, 16'sd0,     16'sd0},
    '{16'sd12868,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd12868, 1'b0, 16'sd0,     16'sd0},
    '{16'sd12867,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd12867, 1'b0, 16'sd0,     16'sd0},
    '{16'sd12869,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd12869, 1'b0, 16'sd0,     16'sd0},
    '{16'sd6435,   1'b0, 16'sd0,     16'sd0},
    '{-16'sd6434,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd6435,  1'b0, 16'sd0,     16'sd0},
    '{16'sd1,      1'b0, 16'sd0,     16'sd0},
    '{-16'sd1,     1'b0, 16'sd0,     16'sd0},
    '{16'sd25736,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd25736, 1'b0, 16'sd0,     16'sd0},
    '{16'sd19302,  1'b0, 16'sd0,     16'sd0},
    '{-16'sd19302, 1'b0, 16'sd0,     16'sd0},
    '{16'sd16384,  1'b0, 16'sd0,     16'sd0}
  };

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [AngleW-1:0] angle_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [TrigW-1:0]  sine_o;
  logic signed [TrigW-1:0]  cosine_o;

  trig_t       expected_trig_q [$];
  int unsigned err_cnt;
  int unsigned accepted_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_rx;

  parabolic_sine_cosine_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .angle_i     (angle_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sine_o      (sine_o),
    .cosine_o    (cosine_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint round_half_away(input longint v, input int sh);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (longint'(1) << (sh - 1))) >>> sh;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic logic signed [TrigW-1:0] parabola_sine(input int x);
    longint xl;
    longint xa;
    longint quad;
    longint p;
    longint pa;
    longint t;
    longint y;
    xl   = longint'(x);
    xa   = (xl < 0) ? -xl : xl;
    quad = round_half_away(longint'(CoefC) * (xl * xa), 12);
    p    = round_half_away(longint'(CoefB) * xl - quad, 12);
    pa   = (p < 0) ? -p : p;
    t    = p * pa - p * longint'(OneQ14);
    y    = p + round_half_away(longint'(CoefP) * t, 30);
    if (y > longint'(OneQ14)) begin
      y = longint'(OneQ14);
    end
    if (y < longint'(MinusOneQ14)) begin
      y = longint'(MinusOneQ14);
    end
    return TrigW'(y);
  endfunction

  function automatic trig_t predict_trig(input logic signed [AngleW-1:0] angle);
    trig_t res;
    int    x;
    x = int'(angle);
    if (x < -int'(AngPi)) begin
      x = x + int'(AngTwoPi);
    end else if (x > int'(AngPi)) begin
      x = x - int'(AngTwoPi);
    end
    res.sine = parabola_sine(x);
    x = x + int'(AngHalfPi);
    if (x > int'(AngPi)) begin
      x = x - int'(AngTwoPi);
    end
    res.cosine = parabola_sine(x);
    return res;
  endfunction

  function automatic logic signed [AngleW-1:0] random_angle();
    int          pick;
    int          base;
    int unsigned raw;
    pick = $urandom_range(9);
    raw  = $urandom();
    if (pick < 6) begin
      return AngleW'(raw);
    end else if (pick < 8) begin
      case ($urandom_range(4))
        0: base = int'(AngPi);
        1: base = -int'(AngPi);
        2: base = int'(AngHalfPi);
        3: base = int'(AngTwoPi);
        default: base = -int'(AngTwoPi);
      endcase
      return AngleW'(base + int'($urandom_range(8)) - 4);
    end
    return AngleW'(int'($urandom_range(2 * int'(AngPi))) - int'(AngPi));
  endfunction

  task automatic report_mismatch(input string what, input int exp_v, input int got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    err_cnt++;
  endtask

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_angle(input logic signed [AngleW-1:0] angle, input logic typed,
                            input trig_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    angle_i    = angle;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    expected_trig_q.push_back(typed ? typed_res : predict_trig(angle));
    accepted_cnt++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    trig_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_trig_q.size() == 0) begin
        $display("[%0t] result with no transfer pending: sine %0d, cosine %0d", $time,
                 sine_o, cosine_o);
        err_cnt++;
      end else begin
        exp_res = expected_trig_q.pop_front();
        if (sine_o !== exp_res.sine) begin
          report_mismatch("sine", int'(exp_res.sine), int'(sine_o));
        end
        if (cosine_o !== exp_res.cosine) begin
          report_mismatch("cosine", int'(exp_res.cosine), int'(cosine_o));
        end
      end
    end
  end

  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      out_ready_i = !hold_rx && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    hold_rx = 1'b0;
    wait (accepted_cnt >= HoldAfter);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    trig_t typed_res;
    int    wait_cnt;
    err_cnt       = 0;
    accepted_cnt  = 0;
    cycle_cnt     = 0;
    send_idle_pct = 12;
    recv_idle_pct = 70;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    angle_i       = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirRows; i++) begin
      typed_res.sine   = DirTbl[i].sine;
      typed_res.cosine = DirTbl[i].cosine;
      send_angle(DirTbl[i].angle, DirTbl[i].typed, typed_res);
    end

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < RandPerMode; n++) begin
        send_angle(random_angle(), 1'b0, '0);
      end
    end
    in_valid_i = 1'b0;

    wait (expected_trig_q.size() == 0);
    wait_cnt = 0;
    while (wait_cnt < NumStages + 20) begin
      @(posedge clk_i);
      wait_cnt++;
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/psc_pkg.sv
rtl/core/psc_sine_pipe.sv
rtl/core/parabolic_sine_cosine_core.sv
tb/tb_parabolic_sine_cosine_core.sv
